[sv/etf_pkg.sv]
// Shared types, constants and pitch table builder for the note-to-frequency core.
package etf_pkg;

  localparam int OCTAVES_DEF   = 4;
  localparam int FRAC_BITS_DEF = 30;
  localparam int ROM_SIZE      = 144;
  localparam int ADDR_W        = 8;
  localparam int OCT_W         = 3;
  localparam int KEY_W         = 8;
  localparam int VEL_W         = 7;
  localparam int FREQ_W        = 36;
  localparam int STEPS_W       = 6;
  localparam int BASE_W        = 32;
  localparam int RANGE_W       = 9;

  localparam logic [STEPS_W-1:0] STEPS_19 = 6'd19;
  localparam logic [STEPS_W-1:0] STEPS_31 = 6'd31;
  localparam logic [STEPS_W-1:0] STEPS_41 = 6'd41;
  localparam logic [STEPS_W-1:0] STEPS_53 = 6'd53;

  localparam real INV_19 = 1.0 / 19.0;
  localparam real INV_31 = 1.0 / 31.0;
  localparam real INV_41 = 1.0 / 41.0;
  localparam real INV_53 = 1.0 / 53.0;

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_19;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd1802240;

  localparam logic REG_STEPS = 1'b0;
  localparam logic REG_BASE  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key_number;
    logic [VEL_W-1:0] note_velocity;
  } note_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [VEL_W-1:0]  velocity_out;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rom_addr;
    logic [OCT_W-1:0]  octave;
    logic [VEL_W-1:0]  velocity;
  } work_t;

  typedef logic [63:0] rom_tab_t [ROM_SIZE];

  function automatic logic [ADDR_W-1:0] bank_offset(input logic [STEPS_W-1:0] n);
    logic [ADDR_W-1:0] off;
    unique case (n)
      STEPS_31: off = 8'd19;
      STEPS_41: off = 8'd50;
      STEPS_53: off = 8'd91;
      default:  off = 8'd0;
    endcase
    return off;
  endfunction

  function automatic logic valid_steps(input logic [STEPS_W-1:0] n);
    return (n == STEPS_19) || (n == STEPS_31) || (n == STEPS_41) || (n == STEPS_53);
  endfunction

  // round(2^(r/n) * 2^frac) for every r of each bank, at elaboration
  function automatic rom_tab_t build_rom(input int frac);
    rom_tab_t tab;
    int r;
    real inv;
    real v;
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (i < 19) begin
        inv = INV_19;
        r = i;
      end else if (i < 50) begin
        inv = INV_31;
        r = i - 19;
      end else if (i < 91) begin
        inv = INV_41;
        r = i - 50;
      end else begin
        inv = INV_53;
        r = i - 91;
      end
      v = $pow(2.0, real'(r) * inv) * $pow(2.0, real'(frac));
      tab[i] = 64'(longint'(v));
    end
    return tab;
  endfunction

endpackage

[sv/etf_front.sv]
// Front end: takes a note, checks its key range and splits it into octave and table address.
module etf_front import etf_pkg::*; #(
  parameter int OCTAVES = OCTAVES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  note_t               note,
  input  logic [STEPS_W-1:0]  steps,
  output logic                push,
  output work_t               work
);

  logic [RANGE_W-1:0] key_ext;
  logic [RANGE_W-1:0] limit;
  logic [RANGE_W-1:0] sub;
  logic [OCT_W-1:0]   oct;
  logic [ADDR_W-1:0]  r;
  logic               in_range;

  always_comb begin
    key_ext  = RANGE_W'(note.key_number);
    limit    = RANGE_W'(OCTAVES * int'(steps));
    in_range = key_ext < limit;
    oct      = '0;
    sub      = '0;
    for (int k = 1; k < OCTAVES; k++) begin
      if (key_ext >= RANGE_W'(k * int'(steps))) begin
        oct = OCT_W'(k);
        sub = RANGE_W'(k * int'(steps));
      end
    end
    r = ADDR_W'(key_ext - sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= take && in_range;
    end
    work.rom_addr <= bank_offset(steps) + r;
    work.octave   <= oct;
    work.velocity <= note.note_velocity;
  end

endmodule

[sv/etf_queue.sv]
// Two-entry queue between the front end and the back end.
module etf_queue import etf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output logic  nonempty,
  output logic  full,
  output work_t head
);

  work_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign nonempty = count != 2'd0;
  assign full     = count == 2'd2;
  assign head     = slot[rd_ptr];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(do_pop);
    end
    if (push && !full) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/etf_back.sv]
// Back end: table read, scale by the base frequency, octave shift and saturation.
module etf_back import etf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  work_t              work,
  input  logic [BASE_W-1:0]  base,
  output logic               done,
  output result_t            result
);

  localparam int ROM_W  = FRAC_BITS + 1;
  localparam int PROD_W = BASE_W + ROM_W;
  localparam rom_tab_t ROM = build_rom(FRAC_BITS);

  logic               v1;
  logic               v2;
  logic [ROM_W-1:0]   rom_q;
  logic [OCT_W-1:0]   oct1;
  logic [OCT_W-1:0]   oct2;
  logic [VEL_W-1:0]   vel1;
  logic [VEL_W-1:0]   vel2;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  shifted;

  assign shifted = prod >> (FRAC_BITS - int'(oct2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= valid;
      v2   <= v1;
      done <= v2;
    end
    rom_q <= ROM_W'(ROM[work.rom_addr]);
    oct1  <= work.octave;
    vel1  <= work.velocity;
    prod  <= PROD_W'(base) * PROD_W'(rom_q);
    oct2  <= oct1;
    vel2  <= vel1;
    if (|shifted[PROD_W-1:FREQ_W]) begin
      result.frequency <= '1;
    end else begin
      result.frequency <= shifted[FREQ_W-1:0];
    end
    result.velocity_out <= vel2;
  end

endmodule

[sv/equal_temperament_note_to_freq_core.sv]
// Top level: configuration registers, front end, queue and back end.
//
// Converts a key number to an equal-temperament frequency in Q20.16 hertz,
// base_frequency * 2^(key/N), with N steps per octave (19, 31, 41 or 53).
// One note is taken per clock while busy is low; done pulses with the result
// once the note has passed the front register, which loads at the edge that
// takes start, the queue and the three back-end stages (table read, 32-bit
// multiply, shift and saturate). Keys at or above OCTAVES*N give no done
// pulse. The result is shown for one cycle only and
// cannot be held off. Register 0 (address 0) is the step count, register 1
// (address 4) the base frequency; unsupported step counts and a zero base are
// ignored. Write registers only while no note is in flight.
module equal_temperament_note_to_freq_core import etf_pkg::*; #(
  parameter int OCTAVES   = OCTAVES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  note_t        note,
  output logic         done,
  output result_t      result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [STEPS_W-1:0] steps;
  logic [BASE_W-1:0]  base;
  logic               wr_en;
  logic               push;
  work_t              front_work;
  logic               nonempty;
  logic               full;
  work_t              head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign busy   = full;
  assign prdata = (paddr[2] == REG_BASE) ? base : 32'(steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEPS_RESET;
      base  <= BASE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_STEPS) begin
        if (valid_steps(pwdata[STEPS_W-1:0])) begin
          steps <= pwdata[STEPS_W-1:0];
        end
      end else begin
        if (pwdata != 32'd0) begin
          base <= pwdata;
        end
      end
    end
  end

  etf_front #(
    .OCTAVES (OCTAVES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (start && !busy),
    .note  (note),
    .steps (steps),
    .push  (push),
    .work  (front_work)
  );

  etf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_work),
    .pop       (nonempty),
    .nonempty  (nonempty),
    .full      (full),
    .head      (head)
  );

  etf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (nonempty),
    .work   (head),
    .base   (base),
    .done   (done),
    .result (result)
  );

endmodule

[tb/tb_equal_temperament_note_to_freq_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the equal-temperament key-to-frequency core.
module tb_equal_temperament_note_to_freq_core;
  import etf_pkg::*;

  localparam int LIMBS = 112;
  localparam logic [FREQ_W-1:0] FREQ_SAT = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  note_t             note = '0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic              busy;
  logic              done;
  result_t           result;
  logic [31:0]       prdata;
  logic              pready;

  logic [STEPS_W-1:0] steps_cfg;
  logic [BASE_W-1:0]  base_cfg;
  logic [63:0]        ratio_table [ROM_SIZE];
  note_t              pending_notes [$];
  result_t            expected_results [$];
  int                 mismatches = 0;
  int                 gap_left = 0;
  bit                 idle_on = 1'b1;
  bit                 item_taken = 1'b0;

  equal_temperament_note_to_freq_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .note    (note),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // exact test of a^n <= 2^e, 16 bits per limb
  function automatic bit odd_pow_le_pow2(longint unsigned a, int n, int e);
    longint unsigned limb [LIMBS];
    longint unsigned t;
    longint unsigned carry;
    longint unsigned want;
    for (int i = 0; i < LIMBS; i++) limb[i] = 0;
    limb[0] = 1;
    for (int k = 0; k < n; k++) begin
      carry = 0;
      for (int i = 0; i < LIMBS; i++) begin
        t = limb[i] * a + carry;
        limb[i] = t & 64'hFFFF;
        carry = t >> 16;
      end
    end
    for (int i = LIMBS - 1; i >= 0; i--) begin
      want = (i == e / 16) ? (64'd1 << (e % 16)) : 64'd0;
      if (limb[i] != want) return limb[i] < want;
    end
    return 1'b1;
  endfunction

  // round(2^(r/n) * 2^FRAC_BITS), estimate then exact correction
  function automatic logic [63:0] ratio_entry(int r, int n);
    real est;
    longint unsigned m;
    int e;
    e = r + (FRAC_BITS_DEF + 1) * n;
    est = $pow(2.0, real'(r) / real'(n)) * $pow(2.0, real'(FRAC_BITS_DEF));
    m = longint'($floor(est + 0.5));
    while (!odd_pow_le_pow2(2 * m - 1, n, e)) m--;
    while (odd_pow_le_pow2(2 * m + 1, n, e)) m++;
    return m;
  endfunction

  function automatic int bank_start(int n);
    case (n)
      31: return 19;
      41: return 50;
      53: return 91;
      default: return 0;
    endcase
  endfunction

  function automatic bit supported_steps(int n);
    return n == STEPS_19 || n == STEPS_31 || n == STEPS_41 || n == STEPS_53;
  endfunction

  function automatic bit predict_note(note_t nt, output result_t res);
    int n;
    int octave;
    int r;
    logic [63:0] prod;
    logic [63:0] scaled;
    n = int'(steps_cfg);
    if (!supported_steps(n)) n = int'(STEPS_19);
    res = '0;
    if (int'(nt.key_number) >= OCTAVES_DEF * n) return 1'b0;
    octave = int'(nt.key_number) / n;
    r = int'(nt.key_number) % n;
    prod = 64'(base_cfg) * ratio_table[bank_start(n) + r];
    scaled = prod >> (FRAC_BITS_DEF - octave);
    res.frequency = (scaled > 64'(FREQ_SAT)) ? FREQ_SAT : scaled[FREQ_W-1:0];
    res.velocity_out = nt.note_velocity;
    return 1'b1;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_and_accept
    result_t want;
    if (rst) begin
      item_taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result freq=%h vel=%0d",
                                  result.frequency, result.velocity_out));
        end else begin
          want = expected_results.pop_front();
          if (result.frequency !== want.frequency)
            note_mismatch($sformatf("frequency expected %h actual %h",
                                    want.frequency, result.frequency));
          if (result.velocity_out !== want.velocity_out)
            note_mismatch($sformatf("velocity expected %0d actual %0d",
                                    want.velocity_out, result.velocity_out));
        end
      end
      item_taken = start && !busy;
      if (item_taken) begin
        void'(pending_notes.pop_front());
        if (predict_note(note, want)) expected_results.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold until taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      gap_left <= $urandom_range(1, 14) - 1;
      start <= 1'b0;
    end else if (pending_notes.size() > 0) begin
      start <= 1'b1;
      note <= pending_notes[0];
    end else begin
      start <= 1'b0;
    end
  end

  task automatic apb_access(bit wr, logic idx, logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_STEPS) begin
      if (supported_steps(int'(value[STEPS_W-1:0]))) steps_cfg = value[STEPS_W-1:0];
      want = 32'(steps_cfg);
    end else begin
      if (value != 0) base_cfg = value;
      want = base_cfg;
    end
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== want)
      note_mismatch($sformatf("register %0d readback expected %h actual %h", idx, want, rd));
  endtask

  task automatic push_note(int key, int vel);
    note_t nt;
    nt.key_number = key[KEY_W-1:0];
    nt.note_velocity = vel[VEL_W-1:0];
    pending_notes.push_back(nt);
  endtask

  task automatic settle();
    while (pending_notes.size() != 0 || start) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic run_random(int count);
    int key;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) key = $urandom_range(0, OCTAVES_DEF * steps_cfg - 1);
      else key = $urandom_range(0, 255);
      push_note(key, $urandom_range(0, 127));
    end
    settle();
  endtask

  initial begin : stimulus
    logic [STEPS_W-1:0] step_choices [4];
    logic [31:0] base_val;
    int bad;
    step_choices = '{STEPS_19, STEPS_31, STEPS_41, STEPS_53};
    foreach (step_choices[b])
      for (int r = 0; r < step_choices[b]; r++)
        ratio_table[bank_start(step_choices[b]) + r] = ratio_entry(r, step_choices[b]);
    steps_cfg = STEPS_RESET;
    base_cfg = BASE_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_STEPS, 32'd20);
    write_reg(REG_STEPS, 32'd0);
    write_reg(REG_STEPS, 32'd63);
    write_reg(REG_BASE, 32'd0);
    push_note(0, 0);
    push_note(0, 127);
    push_note(18, 85);
    push_note(19, 42);
    push_note(75, 1);
    push_note(76, 127);
    push_note(255, 0);
    push_note(128, 64);
    settle();

    write_reg(REG_STEPS, 32'(STEPS_53));
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    push_note(0, 127);
    push_note(211, 0);
    push_note(212, 5);
    push_note(105, 85);
    push_note(170, 42);
    settle();

    write_reg(REG_STEPS, 32'(STEPS_31));
    write_reg(REG_BASE, 32'd1);
    push_note(0, 1);
    push_note(123, 126);
    push_note(124, 3);
    settle();

    write_reg(REG_STEPS, 32'(STEPS_41));
    write_reg(REG_BASE, BASE_RESET);
    push_note(163, 127);
    push_note(164, 0);
    push_note(82, 99);
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: base_val = $urandom;
        1: base_val = 32'd1;
        2: base_val = 32'hFFFF_FFFF;
        3: base_val = BASE_RESET;
        default: base_val = $urandom_range(1, 32'h00FF_FFFF);
      endcase
      write_reg(REG_STEPS, 32'(step_choices[p % 4]));
      write_reg(REG_BASE, base_val);
      if ($urandom_range(0, 1)) begin
        do bad = $urandom_range(0, 63); while (supported_steps(bad));
        write_reg(REG_STEPS, 32'(bad));
      end
      if (p % 3 == 0) write_reg(REG_BASE, 32'd0);
      if (p == 9) idle_on = 1'b0;
      run_random(110);
    end

    repeat (20) @(negedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
sv/etf_pkg.sv
sv/etf_front.sv
sv/etf_queue.sv
sv/etf_back.sv
sv/equal_temperament_note_to_freq_core.sv
tb/tb_equal_temperament_note_to_freq_core.sv
